[design/ptct_pkg.sv]
// Package for the periodic tick catch-up timer.
// Request codes, field widths, guard constant and the shared unit result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptct_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned TickW   = 8;
  localparam int unsigned TotalW  = 16;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  localparam logic [CountW-1:0] GuardCounts = CountW'(12);

  typedef enum logic [ReqW-1:0] {
    REQ_START   = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_DRAIN   = 2'd2,
    REQ_NONE    = 2'd3
  } ptct_req_e;

  typedef struct packed {
    logic              done;
    logic [TickW-1:0]  ticks;
    logic [CountW-1:0] advance;
  } ptct_res_t;

endpackage

`default_nettype wire

[design/periodic_tick_catchup_timer_unit.sv]
// Start, drain and ignored requests pass IDLE and DONE; on-time service also passes LATE and CHECK;
// late service also waits in WAIT (32 divide steps and 8 multiply steps on one adder).
// One transfer at a time; the input is not ready while a request runs.
// The output register lets the next transfer be accepted while a result waits.
// Reset (async, active low) clears period, compare value, pending and total counts.
// Depends on ptct_pkg and ptct_divmul.
`timescale 1ns / 1ps
`default_nettype none

module periodic_tick_catchup_timer_unit import ptct_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,   // tick_period
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i, // req_type[1:0], timer_count[33:2]
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // compare_value[31:0], ticks_added[39:32], released_ticks[47:40],
  // pending_ticks[55:48], tick_total[71:56]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LATE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } ptct_state_e;

  ptct_state_e state_q, state_d;
  logic [CountW-1:0] period_q;
  logic [CountW-1:0] cmp_q, cmp_d;
  logic [TickW-1:0]  pend_q, pend_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [TickW-1:0]  added_q, added_d;
  logic [TickW-1:0]  rel_q, rel_d;
  logic [CountW-1:0] now_q, now_d;
  logic [CountW-1:0] late_q, late_d;
  logic              ovalid_q, ovalid_d;
  logic [OutDataW-1:0] odata_q, odata_d;

  logic              in_xfer;
  ptct_req_e         req;
  logic [CountW-1:0] in_count;
  logic              unit_start;
  logic [CountW-1:0] biased;
  ptct_res_t         unit_res;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign req      = ptct_req_e'(s_axis_tdata_i[ReqW-1:0]);
  assign in_count = s_axis_tdata_i[ReqW+CountW-1:ReqW];
  assign biased   = late_q + {1'b0, period_q[CountW-1:1]};

  ptct_divmul u_divmul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .dividend_i (biased),
    .divisor_i  (period_q),
    .res_o      (unit_res)
  );

  always_comb begin
    state_d    = state_q;
    cmp_d      = cmp_q;
    pend_d     = pend_q;
    total_d    = total_q;
    added_d    = added_q;
    rel_d      = rel_q;
    now_d      = now_q;
    late_d     = late_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    unit_start = 1'b0;
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          added_d = '0;
          rel_d   = '0;
          now_d   = in_count;
          state_d = S_DONE;
          if (period_q != '0) begin
            unique case (req)
              REQ_START: cmp_d = in_count + period_q;
              REQ_SERVICE: state_d = S_LATE;
              REQ_DRAIN: begin
                rel_d  = pend_q;
                pend_d = '0;
              end
              default: ;
            endcase
          end
        end
      end
      S_LATE: begin
        late_d  = now_q - cmp_q;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (late_q < period_q - GuardCounts) begin
          cmp_d   = cmp_q + period_q;
          added_d = TickW'(1);
          pend_d  = pend_q + TickW'(1);
          total_d = total_q + TotalW'(1);
          state_d = S_DONE;
        end else begin
          unit_start = 1'b1;
          state_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (unit_res.done) begin
          cmp_d   = cmp_q + unit_res.advance;
          added_d = unit_res.ticks;
          pend_d  = pend_q + unit_res.ticks;
          total_d = total_q + {{(TotalW-TickW){1'b0}}, unit_res.ticks};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = {total_q, pend_q, rel_q, added_q, cmp_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      period_q <= '0;
      cmp_q    <= '0;
      pend_q   <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmp_q    <= cmp_d;
      pend_q   <= pend_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    added_q <= added_d;
    rel_q   <= rel_d;
    now_q   <= now_d;
    late_q  <= late_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

`default_nettype wire

[design/ptct_divmul.sv]
// Iterative divide/multiply unit on one shared 33-bit adder.
// Computes n = (dividend / divisor + 1) mod 256, then n * divisor mod 2^32.
// Depends on ptct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptct_divmul import ptct_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CountW-1:0] dividend_i,
  input  wire logic [CountW-1:0] divisor_i,
  output ptct_res_t              res_o
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_DIV  = 3'b010,
    U_MUL  = 3'b100
  } ptct_ustate_e;

  ptct_ustate_e state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvd_q, dvd_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [TickW-1:0]  quo_q, quo_d;
  logic [TickW-1:0]  mlr_q, mlr_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] mc_q, mc_d;
  logic              done_q, done_d;

  logic [CountW:0]   op_a, op_b, trial;
  logic              cin;
  logic [CountW+1:0] sum;
  logic              ge;
  logic [TickW-1:0]  quo_next;

  assign trial = {rem_q, dvd_q[CountW-1]};

  // shared adder
  always_comb begin
    if (state_q == U_DIV) begin
      op_a = trial;
      op_b = ~{1'b0, dvs_q};
      cin  = 1'b1;
    end else begin
      op_a = {1'b0, acc_q};
      op_b = {1'b0, mc_q};
      cin  = 1'b0;
    end
    sum = {1'b0, op_a} + {1'b0, op_b} + {{(CountW+1){1'b0}}, cin};
  end

  assign ge       = sum[CountW+1];
  assign quo_next = {quo_q[TickW-2:0], ge};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    mlr_d   = mlr_q;
    acc_d   = acc_q;
    mc_d    = mc_q;
    done_d  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          rem_d   = '0;
          dvd_d   = dividend_i;
          dvs_d   = divisor_i;
          quo_d   = '0;
          cnt_d   = 5'(CountW - 1);
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        rem_d = ge ? sum[CountW-1:0] : trial[CountW-1:0];
        dvd_d = {dvd_q[CountW-2:0], 1'b0};
        quo_d = quo_next;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          quo_d   = quo_next + TickW'(1);
          mlr_d   = quo_next + TickW'(1);
          acc_d   = '0;
          mc_d    = dvs_q;
          cnt_d   = 5'(TickW - 1);
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        if (mlr_q[0]) begin
          acc_d = sum[CountW-1:0];
        end
        mlr_d = {1'b0, mlr_q[TickW-1:1]};
        mc_d  = {mc_q[CountW-2:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    mlr_q <= mlr_d;
    acc_q <= acc_d;
    mc_q  <= mc_d;
  end

  assign res_o.done    = done_q;
  assign res_o.ticks   = quo_q;
  assign res_o.advance = acc_q;

endmodule

`default_nettype wire
